@@ rtl/tsht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sorted hit table: shared types and codes
// Request and result payloads, table entry layout, operation, status and
// register codes, and the controller state type.
// ----------------------------------------------------------------------------
package tsht_pkg;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_ERASE = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_PREV  = 3'd3,
    KIND_COUNT = 3'd4,
    KIND_CLEAR = 3'd5,
    KIND_NOP6  = 3'd6,
    KIND_NOP7  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_GATE_TIME   = 2'd0,
    REG_GATE_ENABLE = 2'd1,
    REG_GEOM_MASK   = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  localparam logic [31:0] GATE_TIME_RESET = 32'd102400;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  pixel_x;
    logic [2:0]  pixel_y;
    logic [31:0] hit_time;
    logic [2:0]  hit_type;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        prev_found;
    logic [31:0] prev_time;
    logic [6:0]  type_count;
    logic [6:0]  total_count;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  x;
    logic [2:0]  y;
    logic [31:0] time_val;
    logic [2:0]  hit_type;
  } entry_t;

  typedef struct packed {
    logic [31:0] gate_time;
    logic        gate_enable;
    logic [63:0] geometry_mask;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_EV,
    S_ADD_INS,
    S_ERA_RD,
    S_ERA_EV,
    S_REM_RD,
    S_REM_EV,
    S_PRV_RD0,
    S_PRV_EV0,
    S_PRV_RD,
    S_PRV_EV,
    S_CNT_INIT,
    S_CNT_RD,
    S_CNT_EV,
    S_DONE
  } ctrl_state_t;

endpackage

@@ rtl/tsht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hit table storage
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module tsht_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output tsht_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  tsht_pkg::entry_t    wr_data
);
  import tsht_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/tsht_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hit table sequencer
// Walks the table memory one entry per read/evaluate pair to insert, erase,
// compact and search, then counts entries of the requested type.
// ----------------------------------------------------------------------------
module tsht_ctrl #(
  parameter int DEPTH  = 64,
  parameter int GRID_X = 8,
  parameter int GRID_Y = 8,
  parameter int AW     = 6,
  parameter int CW     = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tsht_pkg::req_t    in_req,
  input  tsht_pkg::cfg_t    cfg,
  output logic              out_valid,
  output tsht_pkg::rsp_t    out_rsp,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  tsht_pkg::entry_t  rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output tsht_pkg::entry_t  wr_data
);
  import tsht_pkg::*;

  localparam int WW = (CW > 6) ? CW : 6;

  ctrl_state_t   state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] tcnt_r, tcnt_nxt;
  status_t       status_r, status_nxt;
  logic          found_r, found_nxt;
  logic [31:0]   ptime_r, ptime_nxt;
  logic [2:0]    tx_r, tx_nxt;
  logic [2:0]    ty_r, ty_nxt;

  logic          in_grid;
  logic [5:0]    mask_bit;
  logic          add_ok;
  logic          idx_bad;
  logic [CW-1:0] ptr_ext;
  entry_t        new_entry;

  always_comb begin
    in_grid  = (int'(in_req.pixel_x) < GRID_X) && (int'(in_req.pixel_y) < GRID_Y);
    mask_bit = 6'(int'(in_req.pixel_y) * GRID_X + int'(in_req.pixel_x));
    add_ok   = in_grid && cfg.geometry_mask[mask_bit] &&
               (!cfg.gate_enable || (in_req.hit_time <= cfg.gate_time));
    idx_bad  = WW'(in_req.entry_index) >= WW'(cnt_r);
    ptr_ext  = CW'(ptr_r);
    new_entry.x        = req_r.pixel_x;
    new_entry.y        = req_r.pixel_y;
    new_entry.time_val = req_r.hit_time;
    new_entry.hit_type = req_r.hit_type;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    wptr_r   <= wptr_nxt;
    tcnt_r   <= tcnt_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    ptime_r  <= ptime_nxt;
    tx_r     <= tx_nxt;
    ty_r     <= ty_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    wptr_nxt   = wptr_r;
    tcnt_nxt   = tcnt_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ptime_nxt  = ptime_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    rd_en      = 1'b0;
    rd_addr    = ptr_r;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    wr_data    = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          ptime_nxt  = '0;
          state_nxt  = S_CNT_INIT;
          unique case (kind_t'(in_req.kind))
            KIND_ADD: begin
              if (!add_ok) begin
                status_nxt = ST_REJECTED;
              end else if (cnt_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                wptr_nxt  = '0;
                state_nxt = S_ADD_INS;
              end else begin
                ptr_nxt   = AW'(cnt_r - CW'(1));
                state_nxt = S_ADD_RD;
              end
            end
            KIND_ERASE: begin
              if (idx_bad) begin
                status_nxt = ST_BAD_INDEX;
              end else if (WW'(in_req.entry_index) + WW'(1) < WW'(cnt_r)) begin
                ptr_nxt   = AW'(in_req.entry_index);
                state_nxt = S_ERA_RD;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            KIND_REMOVE: begin
              ptr_nxt  = '0;
              wptr_nxt = '0;
              if (cnt_r != '0) begin
                state_nxt = S_REM_RD;
              end
            end
            KIND_PREV: begin
              if (idx_bad) begin
                status_nxt = ST_BAD_INDEX;
              end else begin
                ptr_nxt   = AW'(in_req.entry_index);
                state_nxt = S_PRV_RD0;
              end
            end
            KIND_CLEAR: cnt_nxt = '0;
            KIND_COUNT, KIND_NOP6, KIND_NOP7: ;
            default: ;
          endcase
        end
      end

      // Insertion walks down from the top, moving later entries up by one.
      S_ADD_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_ADD_EV;
      end
      S_ADD_EV: begin
        if (rd_data.time_val > req_r.hit_time) begin
          wr_en   = 1'b1;
          wr_addr = ptr_r + AW'(1);
          if (ptr_r == '0) begin
            wptr_nxt  = '0;
            state_nxt = S_ADD_INS;
          end else begin
            ptr_nxt   = ptr_r - AW'(1);
            state_nxt = S_ADD_RD;
          end
        end else begin
          wptr_nxt  = ptr_ext + CW'(1);
          state_nxt = S_ADD_INS;
        end
      end
      S_ADD_INS: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(wptr_r);
        wr_data   = new_entry;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_CNT_INIT;
      end

      S_ERA_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ptr_r + AW'(1);
        state_nxt = S_ERA_EV;
      end
      S_ERA_EV: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if ((CW+1)'(ptr_r) + (CW+1)'(2) < (CW+1)'(cnt_r)) begin
          state_nxt = S_ERA_RD;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_CNT_INIT;
        end
      end

      S_REM_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_REM_EV;
      end
      S_REM_EV: begin
        if (rd_data.hit_type != req_r.hit_type) begin
          wr_en    = 1'b1;
          wr_addr  = AW'(wptr_r);
          wptr_nxt = wptr_r + CW'(1);
        end
        if (ptr_ext + CW'(1) == cnt_r) begin
          cnt_nxt   = wptr_nxt;
          state_nxt = S_CNT_INIT;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_REM_RD;
        end
      end

      S_PRV_RD0: begin
        rd_en     = 1'b1;
        state_nxt = S_PRV_EV0;
      end
      S_PRV_EV0: begin
        tx_nxt = rd_data.x;
        ty_nxt = rd_data.y;
        if (ptr_r == '0) begin
          state_nxt = S_CNT_INIT;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          state_nxt = S_PRV_RD;
        end
      end
      S_PRV_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_PRV_EV;
      end
      S_PRV_EV: begin
        if (rd_data.x == tx_r && rd_data.y == ty_r) begin
          found_nxt = 1'b1;
          ptime_nxt = rd_data.time_val;
          state_nxt = S_CNT_INIT;
        end else if (ptr_r == '0) begin
          state_nxt = S_CNT_INIT;
        end else begin
          ptr_nxt   = ptr_r - AW'(1);
          state_nxt = S_PRV_RD;
        end
      end

      S_CNT_INIT: begin
        ptr_nxt   = '0;
        tcnt_nxt  = '0;
        state_nxt = (cnt_r == '0) ? S_DONE : S_CNT_RD;
      end
      S_CNT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CNT_EV;
      end
      S_CNT_EV: begin
        if (rd_data.hit_type == req_r.hit_type) begin
          tcnt_nxt = tcnt_r + CW'(1);
        end
        if (ptr_ext + CW'(1) == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_CNT_RD;
        end
      end

      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    out_rsp.status      = status_r;
    out_rsp.prev_found  = found_r;
    out_rsp.prev_time   = ptime_r;
    out_rsp.type_count  = 7'(tcnt_r);
    out_rsp.total_count = 7'(cnt_r);
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds table depth");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> $stable(cnt_r))
    else $error("entry count changed while idle");
`endif

endmodule

@@ rtl/time_sorted_hit_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sorted hit table
// Keeps pixel hits ordered by time in one memory and serves add, erase,
// remove-by-type, previous-hit, count and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. busy stays high
//   until the result has been shown; out_valid is high for exactly one cycle
//   with the result on out_rsp. The receiver cannot stall, so it must take
//   the result in that cycle.
//   Every request ends with a counting pass over the stored entries. Each
//   visited entry is read from the table memory, which has a single read
//   port, and then evaluated.
//   The user must write the configuration registers through cfg_we /
//   cfg_index / cfg_wdata only while the block is idle; the block itself
//   does not enforce this. Writes take effect at once.
//   Reset (rst_n low, synchronous) empties the table and loads the register
//   defaults; the memory contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module time_sorted_hit_table_unit #(
  parameter int DEPTH  = 64,
  parameter int GRID_X = 8,
  parameter int GRID_Y = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  tsht_pkg::req_t   in_req,
  output logic             out_valid,
  output tsht_pkg::rsp_t   out_rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_wdata
);
  import tsht_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cfg_t          cfg_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_time     <= GATE_TIME_RESET;
      cfg_r.gate_enable   <= 1'b1;
      cfg_r.geometry_mask <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GATE_TIME:   cfg_r.gate_time     <= cfg_wdata[31:0];
        REG_GATE_ENABLE: cfg_r.gate_enable   <= cfg_wdata[0];
        REG_GEOM_MASK:   cfg_r.geometry_mask <= cfg_wdata;
        REG_UNUSED:      ;
        default:         ;
      endcase
    end
  end

  tsht_ctrl #(
    .DEPTH (DEPTH),
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .cfg      (cfg_r),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  tsht_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

@@ verif/tsht_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sorted hit table checker
// Watches accepted requests and configuration writes, keeps its own copy of
// the hit table, predicts each result and compares it with the block output.
// ----------------------------------------------------------------------------
module tsht_checker
  import tsht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  req_t        in_req,
  input  logic        out_valid,
  input  rsp_t        out_rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  entry_t      table_q[$];
  logic [31:0] gate_time_r;
  logic        gate_en_r;
  logic [63:0] geom_r;
  rsp_t        rsp_q[$];
  int          mismatches;

  assign fail_count = mismatches;
  assign pending    = rsp_q.size();

  function automatic logic [6:0] type_tally(logic [2:0] ty);
    logic [6:0] n;
    n = 0;
    foreach (table_q[i]) if (table_q[i].hit_type == ty) n++;
    return n;
  endfunction

  task automatic apply_request(req_t r);
    rsp_t   p;
    entry_t e;
    int     pos;
    entry_t kept[$];
    p = '0;
    case (kind_t'(r.kind))
      KIND_ADD: begin
        if (!geom_r[{r.pixel_y, r.pixel_x}] || (gate_en_r && r.hit_time > gate_time_r))
          p.status = ST_REJECTED;
        else if (table_q.size() >= 64)
          p.status = ST_FULL;
        else begin
          e = '{x: r.pixel_x, y: r.pixel_y, time_val: r.hit_time, hit_type: r.hit_type};
          pos = 0;
          while (pos < table_q.size() && table_q[pos].time_val <= r.hit_time) pos++;
          table_q.insert(pos, e);
        end
      end
      KIND_ERASE: begin
        if (r.entry_index >= table_q.size()) p.status = ST_BAD_INDEX;
        else table_q.delete(r.entry_index);
      end
      KIND_REMOVE: begin
        foreach (table_q[i]) if (table_q[i].hit_type != r.hit_type) kept.push_back(table_q[i]);
        table_q = kept;
      end
      KIND_PREV: begin
        if (r.entry_index >= table_q.size()) p.status = ST_BAD_INDEX;
        else begin
          for (int i = int'(r.entry_index) - 1; i >= 0; i--) begin
            if (table_q[i].x == table_q[r.entry_index].x &&
                table_q[i].y == table_q[r.entry_index].y) begin
              p.prev_found = 1'b1;
              p.prev_time  = table_q[i].time_val;
              break;
            end
          end
        end
      end
      KIND_CLEAR: table_q.delete();
      default: ;
    endcase
    p.type_count  = type_tally(r.hit_type);
    p.total_count = 7'(table_q.size());
    rsp_q.push_back(p);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      table_q.delete();
      rsp_q.delete();
      gate_time_r <= GATE_TIME_RESET;
      gate_en_r   <= 1'b1;
      geom_r      <= '0;
      mismatches  <= 0;
    end else begin
      if (out_valid) begin
        if (rsp_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_rsp);
        end else begin
          if (out_rsp !== rsp_q[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("mismatch: expected st=%0d pf=%0d pt=%h tc=%0d n=%0d",
                       rsp_q[0].status, rsp_q[0].prev_found, rsp_q[0].prev_time,
                       rsp_q[0].type_count, rsp_q[0].total_count);
              $display("          got      st=%0d pf=%0d pt=%h tc=%0d n=%0d",
                       out_rsp.status, out_rsp.prev_found, out_rsp.prev_time,
                       out_rsp.type_count, out_rsp.total_count);
            end
          end
          void'(rsp_q.pop_front());
        end
      end
      if (start && !busy) apply_request(in_req);
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_GATE_TIME:   gate_time_r <= cfg_wdata[31:0];
          REG_GATE_ENABLE: gate_en_r   <= cfg_wdata[0];
          REG_GEOM_MASK:   geom_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ verif/tb_time_sorted_hit_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sorted hit table testbench
// Drives directed and random requests in bursts through several register
// settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_time_sorted_hit_table_unit;
  import tsht_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        in_req = '0;
  logic        out_valid;
  rsp_t        out_rsp;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  logic [31:0] gate_now = GATE_TIME_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  time_sorted_hit_table_unit dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  tsht_checker chk (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  // Called at a falling edge; busy is stable there, so the request is taken
  // at the next rising edge.
  task automatic send_request(req_t r);
    while (busy) @(negedge clk);
    in_req <= r;
    start  <= 1'b1;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] val);
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GATE_TIME) gate_now = val[31:0];
  endtask

  function automatic req_t rand_request();
    req_t r;
    r.kind        = 3'($urandom);
    r.pixel_x     = 3'($urandom);
    r.pixel_y     = 3'($urandom);
    r.hit_type    = 3'($urandom);
    r.entry_index = 6'($urandom);
    case ($urandom_range(0, 3))
      0: r.hit_time = $urandom;
      1: r.hit_time = $urandom_range(0, 300);
      default: r.hit_time = (gate_now == 0) ? 0 : $urandom_range(0, gate_now);
    endcase
    // Lean on adds so the table fills up and overflows now and then.
    if ($urandom_range(0, 9) < 5) r.kind = KIND_ADD;
    else if (r.kind == KIND_CLEAR && $urandom_range(0, 3) != 0) r.kind = KIND_COUNT;
    if ($urandom_range(0, 1)) r.entry_index = 6'($urandom_range(0, 15));
    return r;
  endfunction

  initial begin
    req_t r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests with the reset mask: every add is rejected.
    send_request('{kind: KIND_ADD, pixel_x: 0, pixel_y: 0, hit_time: 0, hit_type: 0,
                   entry_index: 0});
    send_request('{kind: KIND_ERASE, pixel_x: 0, pixel_y: 0, hit_time: 0, hit_type: 0,
                   entry_index: 0});
    send_request('{kind: KIND_PREV, pixel_x: 0, pixel_y: 0, hit_time: 0, hit_type: 7,
                   entry_index: 63});
    write_reg(REG_GEOM_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    // Same pixel twice, equal times, and the gate edge.
    send_request('{KIND_ADD, 3'd7, 3'd7, 32'd102400, 3'd7, 6'd0});
    send_request('{KIND_ADD, 3'd7, 3'd7, 32'd102401, 3'd7, 6'd0});
    send_request('{KIND_ADD, 3'd0, 3'd0, 32'd5, 3'd1, 6'd0});
    send_request('{KIND_ADD, 3'd7, 3'd7, 32'd5, 3'd2, 6'd0});
    send_request('{KIND_PREV, 3'd0, 3'd0, 32'd0, 3'd7, 6'd2});
    send_request('{KIND_PREV, 3'd0, 3'd0, 32'd0, 3'd1, 6'd0});
    send_request('{KIND_COUNT, 3'd0, 3'd0, 32'd0, 3'd7, 6'd0});
    send_request('{KIND_NOP6, 3'd7, 3'd7, 32'hFFFF_FFFF, 3'd7, 6'd63});
    send_request('{KIND_NOP7, 3'd0, 3'd0, 32'd0, 3'd0, 6'd0});
    send_request('{KIND_REMOVE, 3'd0, 3'd0, 32'd0, 3'd7, 6'd0});
    send_request('{KIND_ERASE, 3'd0, 3'd0, 32'd0, 3'd0, 6'd2});
    send_request('{KIND_ERASE, 3'd0, 3'd0, 32'd0, 3'd0, 6'd0});
    send_request('{KIND_CLEAR, 3'd0, 3'd0, 32'd0, 3'd0, 6'd0});
    write_reg(REG_GATE_ENABLE, 64'd0);
    send_request('{KIND_ADD, 3'd3, 3'd4, 32'hFFFF_FFFF, 3'd5, 6'd0});
    // Fill the table past its depth.
    for (int i = 0; i < 66; i++)
      send_request('{KIND_ADD, 3'($urandom), 3'($urandom), $urandom, 3'($urandom), 6'd0});
    send_request('{KIND_PREV, 3'd0, 3'd0, 32'd0, 3'd0, 6'd63});
    send_request('{KIND_ERASE, 3'd0, 3'd0, 32'd0, 3'd0, 6'd63});

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_GATE_TIME, 64'd0); write_reg(REG_GATE_ENABLE, 64'd1); end
        1: begin write_reg(REG_GATE_TIME, 64'hFFFF_FFFF); write_reg(REG_GEOM_MASK, 64'd0); end
        2: begin write_reg(REG_GEOM_MASK, {$urandom, $urandom});
                 write_reg(REG_GATE_TIME, 64'(GATE_TIME_RESET)); end
        3: begin write_reg(REG_GEOM_MASK, 64'h8000_0000_0000_0001 | {$urandom, $urandom});
                 write_reg(REG_GATE_ENABLE, 64'd0); end
        4: begin write_reg(REG_GEOM_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
                 write_reg(REG_GATE_TIME, 64'($urandom)); write_reg(REG_GATE_ENABLE, 64'd1); end
        default: write_reg(REG_GATE_ENABLE, 64'd0);
      endcase
      for (int n = 0; n < 310; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 310; b++, n++) begin
          r = rand_request();
          send_request(r);
        end
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
